FILE: rtl/cbz_pkg.sv
// Shared types and constants for the cubic Bezier point and tangent evaluator.
package cbz_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    localparam int T_W       = 17;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 8;
    localparam int POINT_W   = 16;
    localparam int TAN_W     = 19;
    localparam int NUM_CTRL  = 4;
    localparam int PIPE_LAT  = 5;

    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    localparam int POINT_MAX = 32767;
    localparam int POINT_MIN = -32768;
    localparam int TAN_MAX   = 196608;
    localparam int TAN_MIN   = -196608;

    localparam logic [CFG_IDX_W-1:0] REG_CTRL_P0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_P1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_P2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_P3 = CFG_IDX_W'(3);

    typedef struct packed {
        logic [T_W-1:0] t0;
        logic [T_W-1:0] u0;
        logic [T_W-1:0] t1;
        logic [T_W-1:0] u1;
        logic [T_W-1:0] t2;
        logic [T_W-1:0] u2;
    } cbz_tu_t;

endpackage

FILE: rtl/cbz_axis.sv
// One coordinate axis of the de Casteljau pipeline: point and tangent.
module cbz_axis #(
    parameter int COORD_WIDTH = cbz_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  cbz_pkg::cbz_tu_t                  tu,
    input  logic signed [COORD_WIDTH-1:0]     p [cbz_pkg::NUM_CTRL],
    output logic signed [cbz_pkg::POINT_W-1:0] point,
    output logic signed [cbz_pkg::TAN_W-1:0]   tangent
);

    localparam int QW  = COORD_WIDTH + 17;
    localparam int RW  = COORD_WIDTH + 34;
    localparam int SW  = COORD_WIDTH + 51;
    localparam int TGW = COORD_WIDTH + 36;

    localparam logic signed [SW-1:0]  P_HALF = SW'(64'h0000_8000_0000_0000);
    localparam logic signed [TGW-1:0] T_HALF = TGW'(64'h0000_0000_8000_0000);
    localparam logic signed [SW-1:0]  P_HI   = SW'(cbz_pkg::POINT_MAX);
    localparam logic signed [SW-1:0]  P_LO   = -P_HI - SW'(1);
    localparam logic signed [TGW-1:0] T_HI   = TGW'(cbz_pkg::TAN_MAX);
    localparam logic signed [TGW-1:0] T_LO   = -T_HI;

    logic signed [17:0] ts0, us0, ts1, us1, ts2, us2;

    logic signed [QW-1:0]  q_reg   [3];
    logic signed [QW-1:0]  q_next  [3];
    logic signed [RW-1:0]  r_reg   [2];
    logic signed [RW-1:0]  r_next  [2];
    logic signed [SW-1:0]  s_reg;
    logic signed [SW-1:0]  s_next;
    logic signed [TGW-1:0] tg_reg;
    logic signed [TGW-1:0] tg_next;
    logic signed [TGW-1:0] diff;
    logic signed [SW-1:0]  p_round;
    logic signed [TGW-1:0] t_round;
    logic signed [cbz_pkg::POINT_W-1:0] point_reg;
    logic signed [cbz_pkg::POINT_W-1:0] point_next;
    logic signed [cbz_pkg::TAN_W-1:0]   tan_reg;
    logic signed [cbz_pkg::TAN_W-1:0]   tan_next;

    assign ts0 = $signed({1'b0, tu.t0});
    assign us0 = $signed({1'b0, tu.u0});
    assign ts1 = $signed({1'b0, tu.t1});
    assign us1 = $signed({1'b0, tu.u1});
    assign ts2 = $signed({1'b0, tu.t2});
    assign us2 = $signed({1'b0, tu.u2});

    // level 1: scale 2^16
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_next[i] = QW'(us0) * QW'(p[i]) + QW'(ts0) * QW'(p[i+1]);
        end
    end

    // level 2: scale 2^32
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            r_next[i] = RW'(us1) * RW'(q_reg[i]) + RW'(ts1) * RW'(q_reg[i+1]);
        end
    end

    // level 3: point at scale 2^48, tangent 3*(r1-r0) at scale 2^32
    always_comb
    begin
        s_next  = SW'(us2) * SW'(r_reg[0]) + SW'(ts2) * SW'(r_reg[1]) + P_HALF;
        diff    = TGW'(r_reg[1]) - TGW'(r_reg[0]);
        tg_next = diff + (diff <<< 1) + T_HALF;
    end

    // round (half up, bias added above) and saturate
    always_comb
    begin
        p_round = s_reg >>> 48;
        t_round = tg_reg >>> 32;
        if (p_round > P_HI)
        begin
            point_next = cbz_pkg::POINT_W'(P_HI);
        end
        else if (p_round < P_LO)
        begin
            point_next = cbz_pkg::POINT_W'(P_LO);
        end
        else
        begin
            point_next = p_round[cbz_pkg::POINT_W-1:0];
        end
        if (t_round > T_HI)
        begin
            tan_next = cbz_pkg::TAN_W'(T_HI);
        end
        else if (t_round < T_LO)
        begin
            tan_next = cbz_pkg::TAN_W'(T_LO);
        end
        else
        begin
            tan_next = t_round[cbz_pkg::TAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        r_reg     <= r_next;
        s_reg     <= s_next;
        tg_reg    <= tg_next;
        point_reg <= point_next;
        tan_reg   <= tan_next;
    end

    assign point   = point_reg;
    assign tangent = tan_reg;

endmodule

FILE: rtl/cubic_bezier_point_tangent.sv
// Top level: cubic Bezier curve point and tangent evaluator.
// Timing: done is registered in step with the point and tangent outputs.
// Throughput: one transaction per cycle; busy stays low, five register stages.
// Results cannot be stalled; done marks each result for exactly one cycle.
// Reset: asynchronous, active low; clears control points and pipeline valid bits.
module cubic_bezier_point_tangent #(
    parameter int COORD_WIDTH = cbz_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [cbz_pkg::T_W-1:0]              t_param,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cbz_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cbz_pkg::CFG_W-1:0]            cfg_data,
    output logic                                 done,
    output logic signed [cbz_pkg::POINT_W-1:0]   point_x,
    output logic signed [cbz_pkg::POINT_W-1:0]   point_y,
    output logic signed [cbz_pkg::POINT_W-1:0]   point_z,
    output logic signed [cbz_pkg::TAN_W-1:0]     tangent_x,
    output logic signed [cbz_pkg::TAN_W-1:0]     tangent_y,
    output logic signed [cbz_pkg::TAN_W-1:0]     tangent_z
);

    localparam int PADW = (3 * COORD_WIDTH > cbz_pkg::CFG_W) ? 3 * COORD_WIDTH : cbz_pkg::CFG_W;

    logic [cbz_pkg::CFG_W-1:0] ctrl_reg  [cbz_pkg::NUM_CTRL];
    logic [cbz_pkg::CFG_W-1:0] ctrl_next [cbz_pkg::NUM_CTRL];
    logic [PADW-1:0]           ctrl_pad  [cbz_pkg::NUM_CTRL];

    logic signed [COORD_WIDTH-1:0] coord [3][cbz_pkg::NUM_CTRL];

    logic [cbz_pkg::PIPE_LAT-1:0] valid_reg;
    logic [cbz_pkg::PIPE_LAT-1:0] valid_next;
    cbz_pkg::cbz_tu_t             tu_reg;
    cbz_pkg::cbz_tu_t             tu_next;
    logic [cbz_pkg::T_W-1:0]      t_sat;
    logic                         accept;
    logic                         cfg_write;

    logic signed [cbz_pkg::POINT_W-1:0] point_ax [3];
    logic signed [cbz_pkg::TAN_W-1:0]   tan_ax   [3];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        ctrl_next = ctrl_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                cbz_pkg::REG_CTRL_P0: ctrl_next[0] = cfg_data;
                cbz_pkg::REG_CTRL_P1: ctrl_next[1] = cfg_data;
                cbz_pkg::REG_CTRL_P2: ctrl_next[2] = cfg_data;
                cbz_pkg::REG_CTRL_P3: ctrl_next[3] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < cbz_pkg::NUM_CTRL; k++)
            begin
                ctrl_reg[k] <= '0;
            end
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    for (genvar k = 0; k < cbz_pkg::NUM_CTRL; k++)
    begin : g_pad
        assign ctrl_pad[k] = PADW'(ctrl_reg[k]);
        for (genvar a = 0; a < 3; a++)
        begin : g_ax
            assign coord[a][k] = $signed(ctrl_pad[k][a*COORD_WIDTH +: COORD_WIDTH]);
        end
    end

    // parameter staging, shared by the three axes
    always_comb
    begin
        t_sat      = (t_param > cbz_pkg::T_ONE) ? cbz_pkg::T_ONE : t_param;
        tu_next    = tu_reg;
        tu_next.t2 = tu_reg.t1;
        tu_next.u2 = tu_reg.u1;
        tu_next.t1 = tu_reg.t0;
        tu_next.u1 = tu_reg.u0;
        if (accept)
        begin
            tu_next.t0 = t_sat;
            tu_next.u0 = cbz_pkg::T_ONE - t_sat;
        end
        valid_next = {valid_reg[cbz_pkg::PIPE_LAT-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        tu_reg <= tu_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        cbz_axis #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_axis (
            .clk     (clk),
            .tu      (tu_reg),
            .p       (coord[a]),
            .point   (point_ax[a]),
            .tangent (tan_ax[a])
        );
    end

    assign done      = valid_reg[cbz_pkg::PIPE_LAT-1];
    assign point_x   = point_ax[0];
    assign point_y   = point_ax[1];
    assign point_z   = point_ax[2];
    assign tangent_x = tan_ax[0];
    assign tangent_y = tan_ax[1];
    assign tangent_z = tan_ax[2];

endmodule

FILE: rtl/cbz_check.sv
// Port-level checker for the Bezier evaluator, bound to the top level.
module cbz_check (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               done,
    input  logic signed [cbz_pkg::TAN_W-1:0]   tangent_x,
    input  logic signed [cbz_pkg::TAN_W-1:0]   tangent_y,
    input  logic signed [cbz_pkg::TAN_W-1:0]   tangent_z
);

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("missing result after accepted transaction");

    a_done_caused: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without matching transaction");

    a_tan_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tangent_x >= cbz_pkg::TAN_MIN) && (tangent_x <= cbz_pkg::TAN_MAX)
              && (tangent_y >= cbz_pkg::TAN_MIN) && (tangent_y <= cbz_pkg::TAN_MAX)
              && (tangent_z >= cbz_pkg::TAN_MIN) && (tangent_z <= cbz_pkg::TAN_MAX))
        else $error("tangent out of range");

endmodule

bind cubic_bezier_point_tangent cbz_check u_cbz_check (.*);
